/* rtl/mmp_pkg.sv */
package mmp_pkg;

    // Message byte counter width (length field of the padding)
    localparam int CNT_W = 64;

    // Padding constants
    localparam logic [7:0] MARK_BYTE    = 8'h80;
    localparam logic [3:0] LAST_PAD_IDX = 4'd13;
    localparam logic [3:0] LEN_LO_IDX   = 4'd14;
    localparam logic [3:0] LEN_HI_IDX   = 4'd15;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_ZERO,
        S_LEN_LO,
        S_LEN_HI
    } t_state;

    // Tail word selection for the output register
    typedef enum logic [2:0] {
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN_LO,
        SEL_LEN_HI
    } t_word_sel;

    // Controller to datapath
    typedef struct packed {
        logic      take;   // input request accepted this cycle
        logic      load;   // load a tail word into the output register
        t_word_sel sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic mark_at_13;  // marker word lands on the last padding slot
        logic zero_at_13;  // next zero word is the last padding slot
    } t_dp_sts;

endpackage

/* rtl/mmp_if.sv */
// Input byte channel
interface mmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

// Output word channel
interface mmp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic [3:0]  word_index;
    logic        last_word;

    modport source (output valid, output word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input word, input word_index,
                    input last_word, output ready);
endinterface

// Configuration write channel
interface mmp_cfg_if;
    logic valid;
    logic ready;
    logic length_in_bits;

    modport source (output valid, output length_in_bits, input ready);
    modport sink   (input valid, input length_in_bits, output ready);
endinterface

/* rtl/mmp_datapath.sv */
module mmp_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mmp_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]      i_data_byte,
    input  logic            i_has_byte,
    input  logic            i_cfg_we,
    input  logic            i_cfg_len_bits,
    input  logic            i_out_ready,
    output mmp_pkg::t_dp_sts o_sts,
    output logic            o_out_valid,
    output logic [31:0]     o_word,
    output logic [3:0]      o_word_index,
    output logic            o_last_word
);

    logic [mmp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [23:0]               r_partial, n_partial;
    logic [3:0]                r_widx, n_widx;
    logic                      r_len_bits;
    logic                      r_out_valid, n_out_valid;
    logic [31:0]               r_word, n_word;
    logic [3:0]                r_idx, n_idx;
    logic                      r_last, n_last;

    logic [1:0]                pos;
    logic [4:0]                shamt;
    logic                      out_free;
    logic                      push;
    logic [31:0]               mark_word;
    logic [mmp_pkg::CNT_W-1:0] len_val;

    assign pos      = r_cnt[1:0];
    assign shamt    = {pos, 3'b000};
    assign out_free = !r_out_valid || i_out_ready;
    assign push     = i_cmd.take && i_has_byte;

    // Marker byte goes into the open word at the current byte position
    assign mark_word = {8'h00, r_partial} | (32'(mmp_pkg::MARK_BYTE) << shamt);
    // Length in bits wraps modulo 2^64
    assign len_val   = r_len_bits ? {r_cnt[mmp_pkg::CNT_W-4:0], 3'b000} : r_cnt;

    assign o_sts.out_free   = out_free;
    assign o_sts.mark_at_13 = (r_cnt[5:2] == mmp_pkg::LAST_PAD_IDX);
    assign o_sts.zero_at_13 = (r_widx == mmp_pkg::LAST_PAD_IDX);

    // Byte packing, tail words and output register
    always_comb begin
        n_cnt       = r_cnt;
        n_partial   = r_partial;
        n_widx      = r_widx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_word      = r_word;
        n_idx       = r_idx;
        n_last      = r_last;

        if (push) begin
            n_cnt = r_cnt + mmp_pkg::CNT_W'(1);
            if (pos == 2'd3) begin
                n_partial   = '0;
                n_out_valid = 1'b1;
                n_word      = {i_data_byte, r_partial};
                n_idx       = r_cnt[5:2];
                n_last      = 1'b0;
            end else begin
                n_partial = r_partial | (24'(i_data_byte) << shamt);
            end
        end

        if (i_cmd.load) begin
            n_out_valid = 1'b1;
            n_last      = 1'b0;
            case (i_cmd.sel)
                mmp_pkg::SEL_MARK: begin
                    n_word = mark_word;
                    n_idx  = r_cnt[5:2];
                    n_widx = r_cnt[5:2] + 4'd1;
                end
                mmp_pkg::SEL_ZERO: begin
                    n_word = '0;
                    n_idx  = r_widx;
                    n_widx = r_widx + 4'd1;
                end
                mmp_pkg::SEL_LEN_LO: begin
                    n_word = len_val[31:0];
                    n_idx  = mmp_pkg::LEN_LO_IDX;
                end
                mmp_pkg::SEL_LEN_HI: begin
                    n_word    = len_val[63:32];
                    n_idx     = mmp_pkg::LEN_HI_IDX;
                    n_last    = 1'b1;
                    n_cnt     = '0;
                    n_partial = '0;
                end
                default: begin
                    n_word = '0;
                    n_idx  = r_widx;
                end
            endcase
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_partial   <= '0;
            r_widx      <= '0;
            r_len_bits  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_partial   <= n_partial;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len_bits <= i_cfg_len_bits;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_idx  <= n_idx;
        r_last <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_word       = r_word;
    assign o_word_index = r_idx;
    assign o_last_word  = r_last;

    // Bytes above the fill position of the open word are always clear
    a_partial_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[1:0] == 2'd0) |-> (r_partial == '0))
        else $error("open word holds stale bytes at a word boundary");

    // Only the high length word carries the last flag
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_idx == mmp_pkg::LEN_HI_IDX))
        else $error("last word flagged away from index 15");

    // Message state is cleared once the high length word is loaded
    a_clear_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.sel == mmp_pkg::SEL_LEN_HI)
        |=> (r_cnt == '0 && r_partial == '0))
        else $error("byte count not cleared after the length words");

endmodule

/* rtl/mmp_ctrl.sv */
module mmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_end_of_message,
    input  mmp_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output mmp_pkg::t_dp_cmd o_cmd
);

    mmp_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.take = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.sel  = mmp_pkg::SEL_ZERO;

        case (r_state)
            mmp_pkg::S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_end_of_message) begin
                        n_state = mmp_pkg::S_MARK;
                    end
                end
            end
            mmp_pkg::S_MARK: begin
                o_cmd.sel = mmp_pkg::SEL_MARK;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.mark_at_13 ? mmp_pkg::S_LEN_LO : mmp_pkg::S_ZERO;
                end
            end
            mmp_pkg::S_ZERO: begin
                o_cmd.sel = mmp_pkg::SEL_ZERO;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.zero_at_13) begin
                        n_state = mmp_pkg::S_LEN_LO;
                    end
                end
            end
            mmp_pkg::S_LEN_LO: begin
                o_cmd.sel = mmp_pkg::SEL_LEN_LO;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = mmp_pkg::S_LEN_HI;
                end
            end
            mmp_pkg::S_LEN_HI: begin
                o_cmd.sel = mmp_pkg::SEL_LEN_HI;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = mmp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmp_pkg::S_IDLE;
            end
        endcase
    end

    // A final request always leads into the marker word
    a_end_to_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_end_of_message) |=> (r_state == mmp_pkg::S_MARK))
        else $error("final request did not start the padding tail");

    // Low length word is always followed by the high one
    a_lo_then_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmp_pkg::S_LEN_LO && i_sts.out_free)
        |=> (r_state == mmp_pkg::S_LEN_HI))
        else $error("length words out of order");

    // No new request is taken while the tail is being produced
    a_no_take_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_cmd.take)
        else $error("request taken during padding tail");

endmodule

/* rtl/md5_message_padder_unit.sv */
// Channel  | Dir | Payload                               | Handshake
// i_in     | in  | data_byte[7:0], has_byte, end_of_msg  | valid/ready
// o_out    | out | word[31:0], word_index[3:0], last_word| valid/ready
// i_cfg    | in  | length_in_bits                        | valid/ready, always ready
//
// A request without end_of_message adds no padding; a full word leaves through a single
// output register, so requests flow at one per cycle while it drains and no tail is pending.
// A final request adds a padding tail of 3 to 18 output words, one per cycle while the output
// accepts them, produced by the controller stepping through marker, zero and length words.
// Synchronous active-low reset clears the byte count and sets bit-length mode.
// A stalled output holds the tail and blocks new requests until it moves.
module md5_message_padder_unit (
    input logic            i_clk,
    input logic            i_rst_n,
    mmp_in_if.sink         i_in,
    mmp_out_if.source      o_out,
    mmp_cfg_if.sink        i_cfg
);

    mmp_pkg::t_dp_cmd cmd;
    mmp_pkg::t_dp_sts sts;
    logic             in_ready;

    // Register write is always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // Sequencer for the padding tail
    mmp_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_end_of_message (i_in.end_of_message),
        .i_sts            (sts),
        .o_in_ready       (in_ready),
        .o_cmd            (cmd)
    );

    // Byte packing, counters and output register
    mmp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_byte    (i_in.data_byte),
        .i_has_byte     (i_in.has_byte),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_len_bits (i_cfg.length_in_bits),
        .i_out_ready    (o_out.ready),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .o_word         (o_out.word),
        .o_word_index   (o_out.word_index),
        .o_last_word    (o_out.last_word)
    );

endmodule

/* tb/md5_message_padder_unit_tb.sv */
`timescale 1ns / 100ps

module md5_message_padder_unit_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WAIT   = 24;  // longest padding tail plus margin

    // Per-side idling behaviour
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_FULL
    } t_idle_mode;

    // One expected block word
    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  word_index;
        logic        last_word;
    } t_block_word;

    logic i_clk;
    logic i_rst_n;

    mmp_in_if  in_ch ();
    mmp_out_if out_ch ();
    mmp_cfg_if cfg_ch ();

    md5_message_padder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Padder state as the block should hold it
    logic [63:0]  msg_bytes;
    logic [23:0]  partial_bytes;
    logic         len_in_bits;
    t_block_word  pending_words[$];

    t_idle_mode src_mode;
    t_idle_mode sink_mode;

    int errors;
    int requests_sent;
    int messages_sent;
    int words_checked;
    int cfg_writes;
    int cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("md5_message_padder_unit verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            default:    return $urandom_range(0, 15);
        endcase
    endfunction

    // Add one byte to the padded stream; a completed word becomes an expectation
    function automatic void stream_byte(input logic [7:0] b, input logic is_last);
        logic [1:0]  lane;
        logic [3:0]  slot;
        logic [31:0] w;
        lane = msg_bytes[1:0];
        slot = msg_bytes[5:2];
        w = {8'h00, partial_bytes} | ({24'h0, b} << (8 * lane));
        msg_bytes = msg_bytes + 64'd1;
        if (lane == 2'd3) begin
            pending_words.push_back('{word: w, word_index: slot, last_word: is_last});
            partial_bytes = '0;
        end else begin
            partial_bytes = w[23:0];
        end
    endfunction

    // Expected words for one accepted request
    function automatic void pad_request(input logic [7:0] data, input logic has,
                                        input logic eom);
        logic [63:0] msg_len;
        if (has)
            stream_byte(data, 1'b0);
        if (eom) begin
            msg_len = len_in_bits ? (msg_bytes << 3) : msg_bytes;
            stream_byte(mmp_pkg::MARK_BYTE, 1'b0);
            // zero fill up to the length field at word 14
            while (msg_bytes[5:0] != {mmp_pkg::LEN_LO_IDX, 2'b00})
                stream_byte(8'h00, 1'b0);
            for (int i = 0; i < 8; i++)
                stream_byte(msg_len[8 * i +: 8], i == 7);
            msg_bytes     = '0;
            partial_bytes = '0;
        end
    endfunction

    // Send one request; called and returns just after a falling edge, once it is taken
    task automatic send_request(input logic [7:0] data, input logic has, input logic eom);
        int gap;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.has_byte       <= has;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        pad_request(data, has, eom);
        if (has || eom)
            requests_sent++;
        @(negedge i_clk);
    endtask

    // Let the block go idle: all words out, then the tail latency
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_length_mode(input logic bits_mode);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.length_in_bits <= bits_mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        len_in_bits = bits_mode;
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Message of random content; ends on the last byte or with a separate end request
    task automatic send_message(input int n_bytes);
        logic end_on_byte;
        end_on_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < n_bytes; k++) begin
            // occasional empty request, which the block ignores
            if ($urandom_range(0, 7) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1,
                         end_on_byte && (k == n_bytes - 1));
        end
        if (!end_on_byte)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_sent++;
    endtask

    // Mostly short messages, a good share near the block boundary
    function automatic int draw_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 15);
            6, 7, 8:          return $urandom_range(48, 66);
            default:          return $urandom_range(67, 72);
        endcase
    endfunction

    // Output side: random stalls, every accepted word checked against the oldest expectation
    initial begin : word_sink
        int stall;
        t_block_word exp_w;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(sink_mode);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (pending_words.size() == 0) begin
                $error("unexpected word %h at index %0d", out_ch.word, out_ch.word_index);
                errors++;
            end else begin
                exp_w = pending_words.pop_front();
                if (out_ch.word !== exp_w.word) begin
                    $error("word: expected %h, got %h", exp_w.word, out_ch.word);
                    errors++;
                end
                if (out_ch.word_index !== exp_w.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           exp_w.word_index, out_ch.word_index);
                    errors++;
                end
                if (out_ch.last_word !== exp_w.last_word) begin
                    $error("last_word: expected %b, got %b",
                           exp_w.last_word, out_ch.last_word);
                    errors++;
                end
            end
            words_checked++;
            @(negedge i_clk);
        end
    end

    // Message of only an end request
    task automatic test_empty_message();
        src_mode  = IDLE_LIGHT;
        sink_mode = IDLE_LIGHT;
        send_request(8'hFF, 1'b0, 1'b1);
        messages_sent++;
    endtask

    // Byte and end together, partial words, ignored requests, byte extremes
    task automatic test_short_messages();
        send_request(8'h00, 1'b1, 1'b1);
        messages_sent++;
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hA5, 1'b1, 1'b1);
        messages_sent++;
        send_request(8'h01, 1'b1, 1'b0);
        send_request(8'h02, 1'b1, 1'b0);
        send_request(8'h03, 1'b1, 1'b0);
        send_request(8'h04, 1'b1, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        messages_sent++;
    endtask

    // Length appended as a byte count
    task automatic test_byte_count_mode();
        drain_block();
        write_length_mode(1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        messages_sent++;
        repeat (4) send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1);
        messages_sent++;
        drain_block();
        write_length_mode(1'b1);
    endtask

    // Remainders of 55 and 56 bytes: padding fits one block or spills into a second
    task automatic test_pad_boundary();
        src_mode  = IDLE_FULL;
        sink_mode = IDLE_NONE;
        send_message(55);
        sink_mode = IDLE_FULL;
        send_message(56);
    endtask

    // Random messages in phases of differing length mode and idling
    task automatic random_phase(input logic bits_mode, input t_idle_mode s_mode,
                                input t_idle_mode k_mode, input int n_requests);
        int start;
        drain_block();
        write_length_mode(bits_mode);
        src_mode  = s_mode;
        sink_mode = k_mode;
        start = requests_sent;
        while (requests_sent - start < n_requests)
            send_message(draw_length());
    endtask

    task automatic test_random_traffic();
        random_phase(1'b0, IDLE_FULL, IDLE_FULL,  25);
        random_phase(1'b1, IDLE_NONE, IDLE_NONE,  25);
        random_phase(1'b0, IDLE_NONE, IDLE_FULL,  25);
        random_phase(1'b1, IDLE_LIGHT, IDLE_LIGHT, 25);
    endtask

    // Sequence
    initial begin
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = '0;
        in_ch.has_byte        = 1'b0;
        in_ch.end_of_message  = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.length_in_bits = 1'b0;
        msg_bytes     = '0;
        partial_bytes = '0;
        len_in_bits   = 1'b1;
        src_mode      = IDLE_NONE;
        sink_mode     = IDLE_NONE;
        errors        = 0;
        requests_sent = 0;
        messages_sent = 0;
        words_checked = 0;
        cfg_writes    = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_message();
        test_short_messages();
        test_byte_count_mode();
        test_pad_boundary();
        test_random_traffic();
        drain_block();

        $display("Sent %0d requests in %0d messages, checked %0d words.",
                 requests_sent, messages_sent, words_checked);
        $display("Length register written %0d times, bit and byte modes both used.",
                 cfg_writes);
        if (errors == 0) begin
            $display("md5_message_padder_unit verification clean");
        end else begin
            $display("md5_message_padder_unit verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mmp_pkg.sv
rtl/mmp_if.sv
rtl/mmp_datapath.sv
rtl/mmp_ctrl.sv
rtl/md5_message_padder_unit.sv
tb/md5_message_padder_unit_tb.sv
